### rtl/core/obb_pkg.sv
// Shared constants, types and axis-pair helpers for the oriented box overlap test.
`default_nettype none

package obb_pkg;

	// Default coordinate width (Q8.8 at 16 bits).
	localparam int COORD_BITS_DEF = 16;

	// Four edges: A width, A height, B width, B height. Each one is also a test axis.
	localparam int NUM_EDGES = 4;

	// Distinct edge-by-edge dot products, since dot(i, j) equals dot(j, i).
	localparam int NUM_PAIRS = NUM_EDGES * (NUM_EDGES + 1) / 2;

	// Load enables for the two register stages held by one submodule.
	typedef struct packed {
		logic first;
		logic second;
	} ld_pair_t;

	// Index of the unordered edge pair (i, j), enumerated row by row with lo <= hi.
	function automatic int pair_of(input int i, input int j);
		int lo;
		int hi;
		lo = (i < j) ? i : j;
		hi = (i < j) ? j : i;
		return lo * NUM_EDGES - (lo * (lo - 1)) / 2 + (hi - lo);
	endfunction

	// Lower edge index of pair p.
	function automatic int pair_lo(input int p);
		int r;
		r = 0;
		for (int i = 0; i < NUM_EDGES; i++) begin
			for (int j = i; j < NUM_EDGES; j++) begin
				if (pair_of(i, j) == p) begin
					r = i;
				end
			end
		end
		return r;
	endfunction

	// Upper edge index of pair p.
	function automatic int pair_hi(input int p);
		int r;
		r = 0;
		for (int i = 0; i < NUM_EDGES; i++) begin
			for (int j = i; j < NUM_EDGES; j++) begin
				if (pair_of(i, j) == p) begin
					r = j;
				end
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/obb_overlap_test_2d.sv
// Top level: separating-axis overlap test for two oriented 2D boxes, pipeline control.
//
//   Channel  Handshake             Fields
//   in       in_valid / in_stall   a_*, b_* centers and edge vectors (COORD_BITS each)
//   out      out_valid / out_stall overlap
//
// One box pair is accepted every cycle while in_stall is low; the result passes through
// five register stages (center difference, products, dot magnitudes, axis sums, compare)
// before it is presented on out_valid and overlap.
// The multiplier stage sets the clock: one COORD_BITS by COORD_BITS+1 product per path.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall on the output holds the result and backs up stage by stage; empty stages
// keep accepting, so in_stall rises only when every stage holds a request.
`default_nettype none

module obb_overlap_test_2d #(
	parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire signed [COORD_BITS-1:0]  a_center_x,
	input  wire signed [COORD_BITS-1:0]  a_center_y,
	input  wire signed [COORD_BITS-1:0]  a_width_x,
	input  wire signed [COORD_BITS-1:0]  a_width_y,
	input  wire signed [COORD_BITS-1:0]  a_height_x,
	input  wire signed [COORD_BITS-1:0]  a_height_y,
	input  wire signed [COORD_BITS-1:0]  b_center_x,
	input  wire signed [COORD_BITS-1:0]  b_center_y,
	input  wire signed [COORD_BITS-1:0]  b_width_x,
	input  wire signed [COORD_BITS-1:0]  b_width_y,
	input  wire signed [COORD_BITS-1:0]  b_height_x,
	input  wire signed [COORD_BITS-1:0]  b_height_y,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic                         overlap
);
	import obb_pkg::*;

	localparam int W  = COORD_BITS;
	localparam int AW = 2 * W + 3;

	logic signed [W-1:0]   e_x [NUM_EDGES];
	logic signed [W-1:0]   e_y [NUM_EDGES];
	logic signed [2*W-1:0] px_s2 [NUM_PAIRS];
	logic signed [2*W-1:0] py_s2 [NUM_PAIRS];
	logic signed [2*W:0]   cx_s2 [NUM_EDGES];
	logic signed [2*W:0]   cy_s2 [NUM_EDGES];
	logic [AW-1:0]         acc_s4 [NUM_EDGES];
	logic [AW-1:0]         cd2_s4 [NUM_EDGES];
	logic [NUM_EDGES-1:0]  sep_c;

	logic vld_s1, vld_s2, vld_s3, vld_s4, out_vld_q, overlap_q;
	logic free_s1, free_s2, free_s3, free_s4, free_out;
	ld_pair_t ld_prod, ld_red;

	assign e_x[0] = a_width_x;
	assign e_y[0] = a_width_y;
	assign e_x[1] = a_height_x;
	assign e_y[1] = a_height_y;
	assign e_x[2] = b_width_x;
	assign e_y[2] = b_width_y;
	assign e_x[3] = b_height_x;
	assign e_y[3] = b_height_y;

	// A stage can take a new request when it is empty or its content moves on this cycle.
	assign free_out = !out_vld_q || !out_stall;
	assign free_s4  = !vld_s4 || free_out;
	assign free_s3  = !vld_s3 || free_s4;
	assign free_s2  = !vld_s2 || free_s3;
	assign free_s1  = !vld_s1 || free_s2;
	assign in_stall = !free_s1;

	assign ld_prod = '{first: free_s1, second: free_s2};
	assign ld_red  = '{first: free_s3, second: free_s4};

	obb_prod #(
		.COORD_BITS(COORD_BITS)
	) u_prod (
		.clk   (clk),
		.ld    (ld_prod),
		.e_x   (e_x),
		.e_y   (e_y),
		.a_cx  (a_center_x),
		.a_cy  (a_center_y),
		.b_cx  (b_center_x),
		.b_cy  (b_center_y),
		.px_s2 (px_s2),
		.py_s2 (py_s2),
		.cx_s2 (cx_s2),
		.cy_s2 (cy_s2)
	);

	obb_reduce #(
		.COORD_BITS(COORD_BITS)
	) u_reduce (
		.clk    (clk),
		.ld     (ld_red),
		.px_s2  (px_s2),
		.py_s2  (py_s2),
		.cx_s2  (cx_s2),
		.cy_s2  (cy_s2),
		.acc_s4 (acc_s4),
		.cd2_s4 (cd2_s4)
	);

	// An axis separates when the projected extents fall short of twice the center offset.
	always_comb begin
		for (int i = 0; i < NUM_EDGES; i++) begin
			sep_c[i] = acc_s4[i] < cd2_s4[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (free_s1) begin
				vld_s1 <= in_valid;
			end
			if (free_s2) begin
				vld_s2 <= vld_s1;
			end
			if (free_s3) begin
				vld_s3 <= vld_s2;
			end
			if (free_s4) begin
				vld_s4 <= vld_s3;
			end
			if (free_out) begin
				out_vld_q <= vld_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free_out) begin
			overlap_q <= ~|sep_c;
		end
	end

	assign out_valid = out_vld_q;
	assign overlap   = overlap_q;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && out_vld_q))
		else $error("input stalled while a pipeline stage was empty");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_s1)
		else $error("accepted request did not reach the first stage");

	a_s4_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && out_vld_q && out_stall) |=> (vld_s4 && $stable(sep_c)))
		else $error("last stage changed while the output was stalled");

endmodule

`default_nettype wire

### rtl/core/obb_prod.sv
// Front end: center difference, then all edge and center products, two register stages.
`default_nettype none

module obb_prod #(
	parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF
) (
	input  wire                          clk,
	input  obb_pkg::ld_pair_t            ld,
	input  wire signed [COORD_BITS-1:0]  e_x [obb_pkg::NUM_EDGES],
	input  wire signed [COORD_BITS-1:0]  e_y [obb_pkg::NUM_EDGES],
	input  wire signed [COORD_BITS-1:0]  a_cx,
	input  wire signed [COORD_BITS-1:0]  a_cy,
	input  wire signed [COORD_BITS-1:0]  b_cx,
	input  wire signed [COORD_BITS-1:0]  b_cy,
	output logic signed [2*COORD_BITS-1:0] px_s2 [obb_pkg::NUM_PAIRS],
	output logic signed [2*COORD_BITS-1:0] py_s2 [obb_pkg::NUM_PAIRS],
	output logic signed [2*COORD_BITS:0]   cx_s2 [obb_pkg::NUM_EDGES],
	output logic signed [2*COORD_BITS:0]   cy_s2 [obb_pkg::NUM_EDGES]
);
	import obb_pkg::*;

	localparam int W = COORD_BITS;

	logic signed [W-1:0] ex_s1 [NUM_EDGES];
	logic signed [W-1:0] ey_s1 [NUM_EDGES];
	logic signed [W:0]   dx_s1;
	logic signed [W:0]   dy_s1;

	always_ff @(posedge clk) begin
		if (ld.first) begin
			ex_s1 <= e_x;
			ey_s1 <= e_y;
			dx_s1 <= $signed({b_cx[W-1], b_cx}) - $signed({a_cx[W-1], a_cx});
			dy_s1 <= $signed({b_cy[W-1], b_cy}) - $signed({a_cy[W-1], a_cy});
		end
	end

	always_ff @(posedge clk) begin
		if (ld.second) begin
			for (int p = 0; p < NUM_PAIRS; p++) begin
				px_s2[p] <= ex_s1[pair_lo(p)] * ex_s1[pair_hi(p)];
				py_s2[p] <= ey_s1[pair_lo(p)] * ey_s1[pair_hi(p)];
			end
			for (int i = 0; i < NUM_EDGES; i++) begin
				cx_s2[i] <= ex_s1[i] * dx_s1;
				cy_s2[i] <= ey_s1[i] * dy_s1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/obb_reduce.sv
// Back end: dot products and their magnitudes, then per-axis extent sums and doubled offsets.
`default_nettype none

module obb_reduce #(
	parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF
) (
	input  wire                            clk,
	input  obb_pkg::ld_pair_t              ld,
	input  wire signed [2*COORD_BITS-1:0]  px_s2 [obb_pkg::NUM_PAIRS],
	input  wire signed [2*COORD_BITS-1:0]  py_s2 [obb_pkg::NUM_PAIRS],
	input  wire signed [2*COORD_BITS:0]    cx_s2 [obb_pkg::NUM_EDGES],
	input  wire signed [2*COORD_BITS:0]    cy_s2 [obb_pkg::NUM_EDGES],
	output logic [2*COORD_BITS+2:0]        acc_s4 [obb_pkg::NUM_EDGES],
	output logic [2*COORD_BITS+2:0]        cd2_s4 [obb_pkg::NUM_EDGES]
);
	import obb_pkg::*;

	localparam int W  = COORD_BITS;
	localparam int DW = 2 * W + 1;
	localparam int CW = 2 * W + 2;
	localparam int AW = 2 * W + 3;

	logic signed [DW-1:0] pdot_c [NUM_PAIRS];
	logic signed [CW-1:0] cdot_c [NUM_EDGES];
	logic [DW-1:0]        pabs_s3 [NUM_PAIRS];
	logic [CW-1:0]        cabs_s3 [NUM_EDGES];
	logic [AW-1:0]        acc_c [NUM_EDGES];

	always_comb begin
		for (int p = 0; p < NUM_PAIRS; p++) begin
			pdot_c[p] = $signed({px_s2[p][DW-2], px_s2[p]}) + $signed({py_s2[p][DW-2], py_s2[p]});
		end
		for (int i = 0; i < NUM_EDGES; i++) begin
			cdot_c[i] = $signed({cx_s2[i][CW-2], cx_s2[i]}) + $signed({cy_s2[i][CW-2], cy_s2[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (ld.first) begin
			for (int p = 0; p < NUM_PAIRS; p++) begin
				pabs_s3[p] <= pdot_c[p][DW-1] ? DW'(-pdot_c[p]) : DW'(pdot_c[p]);
			end
			for (int i = 0; i < NUM_EDGES; i++) begin
				cabs_s3[i] <= cdot_c[i][CW-1] ? CW'(-cdot_c[i]) : CW'(cdot_c[i]);
			end
		end
	end

	// Projected extent of both boxes onto axis i, scaled by the axis length.
	always_comb begin
		for (int i = 0; i < NUM_EDGES; i++) begin
			acc_c[i] = '0;
			for (int j = 0; j < NUM_EDGES; j++) begin
				acc_c[i] = acc_c[i] + AW'(pabs_s3[pair_of(i, j)]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld.second) begin
			for (int i = 0; i < NUM_EDGES; i++) begin
				acc_s4[i] <= acc_c[i];
				cd2_s4[i] <= {cabs_s3[i], 1'b0};
			end
		end
	end

endmodule

`default_nettype wire
